// File: src/mmsl_pkg.sv
// ----------------------------------------------------------------------------
// mmsl_pkg: shared widths, types and constants for the mecanum mixer
// Widths of the mixed sums, magnitudes and the one-bit-per-stage divider,
// plus the structs that travel down the divider pipeline.
// ----------------------------------------------------------------------------
package mmsl_pkg;

    // Field widths
    localparam int IN_W   = 16;  // vx, vy, wz
    localparam int LIM_W  = 15;  // speed_limit
    localparam int OUT_W  = 16;  // wheel outputs
    localparam int LANES  = 4;   // wheels

    // Three 16-bit terms need two extra bits
    localparam int SUM_W  = IN_W + 2;
    // Magnitude of a sum is at most 3 * 2^15
    localparam int MAG_W  = SUM_W - 1;
    // magnitude * limit
    localparam int PROD_W = MAG_W + LIM_W;
    // Scaled magnitude never exceeds the limit
    localparam int Q_W    = LIM_W;

    // One quotient bit per divider stage
    localparam int DIV_STAGES = Q_W;
    // mix, magnitude, peak, multiply, divider stages, output register
    localparam int LATENCY    = 4 + DIV_STAGES + 1;

    // Wheel order in all lane arrays
    localparam int W_LF = 0;
    localparam int W_RF = 1;
    localparam int W_RB = 2;
    localparam int W_LB = 3;

    // Partial remainder and shifting dividend/quotient word of one lane
    typedef struct packed {
        logic [MAG_W-1:0] rem;
        logic [Q_W-1:0]   qn;
    } lane_t;

    typedef lane_t [LANES-1:0] lanes_t;

    // Side band that travels with the lanes
    typedef struct packed {
        logic             valid;
        logic             scale;
        logic [MAG_W-1:0] divisor;
        logic [LANES-1:0] neg;
    } ctl_t;

endpackage

// File: src/mecanum_mix_speed_limit.sv
// ----------------------------------------------------------------------------
// mecanum_mix_speed_limit: mecanum wheel mixer with proportional speed limit
// Mixes (vx, vy, wz) into four wheel speeds and scales all of them by
// speed_limit / peak when the largest magnitude exceeds the limit.
// ----------------------------------------------------------------------------
// Usage:
//   Drive vx, vy, wz and speed_limit and pulse start. An item is taken at
//   every rising edge with start high and busy low; busy is always low, so
//   a new item may enter on every cycle.
//   Each result appears on wheel_lf, wheel_rf, wheel_rb, wheel_lb and
//   was_scaled for exactly one cycle, marked by done. Results leave in
//   the order items entered. Throughput is one item per cycle; each item
//   passes the pipeline stages mix, magnitude, peak search, multiply, 15
//   divider stages (one quotient bit each) and the output register.
//   Reset clears all valid bits, so no done pulse follows for items still
//   in flight. The receiver cannot stall: it must take each result in the
//   cycle done is high.
//   Scaled wheels are wheel * limit / peak truncated toward zero; unscaled
//   wheels pass through unchanged.
// ----------------------------------------------------------------------------
module mecanum_mix_speed_limit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic signed [15:0] vx,
    input  logic signed [15:0] vy,
    input  logic signed [15:0] wz,
    input  logic [14:0] speed_limit,
    output logic        done,
    output logic signed [15:0] wheel_lf,
    output logic signed [15:0] wheel_rf,
    output logic signed [15:0] wheel_rb,
    output logic signed [15:0] wheel_lb,
    output logic        was_scaled
);

    localparam int SW = mmsl_pkg::SUM_W;
    localparam int MW = mmsl_pkg::MAG_W;
    localparam int LW = mmsl_pkg::LIM_W;
    localparam int NL = mmsl_pkg::LANES;

    // Stage registers
    logic                 v1_reg, v2_reg, v3_reg;
    logic signed [SW-1:0] sum_reg [NL];
    logic [LW-1:0]        lim1_reg, lim2_reg, lim3_reg;
    logic [MW-1:0]        mag2_reg [NL];
    logic [MW-1:0]        mag3_reg [NL];
    logic [NL-1:0]        neg2_reg, neg3_reg;
    logic [MW-1:0]        peak3_reg;
    logic                 scale3_reg;

    logic signed [SW-1:0] ext_x, ext_y, ext_w;
    logic signed [SW-1:0] sum_next [NL];
    logic [MW-1:0]        peak_next;

    logic                 v4_reg;
    logic                 scale4_reg;
    logic [MW-1:0]        divisor4_reg;
    logic [NL-1:0]        neg4_reg;
    mmsl_pkg::lanes_t     lanes4_next;
    mmsl_pkg::lanes_t     lanes4_reg;

    mmsl_pkg::ctl_t       ctl_chain   [mmsl_pkg::DIV_STAGES+1];
    mmsl_pkg::lanes_t     lanes_chain [mmsl_pkg::DIV_STAGES+1];

    logic                 done_reg;
    logic                 scaled_reg;
    logic [mmsl_pkg::OUT_W-1:0] wheel_reg  [NL];
    logic [mmsl_pkg::OUT_W-1:0] wheel_next [NL];

    assign busy = 1'b0;

    // Mix the command into four wheel sums
    assign ext_x = SW'(vx);
    assign ext_y = SW'(vy);
    assign ext_w = SW'(wz);

    always_comb
    begin
        sum_next[mmsl_pkg::W_LF] =  ext_x + ext_y + ext_w;
        sum_next[mmsl_pkg::W_RF] =  ext_x - ext_y + ext_w;
        sum_next[mmsl_pkg::W_RB] = -ext_x - ext_y + ext_w;
        sum_next[mmsl_pkg::W_LB] = -ext_x + ext_y + ext_w;
    end

    // Find the peak magnitude with a two-level compare tree
    always_comb
    begin
        logic [MW-1:0] pa;
        logic [MW-1:0] pb;
        pa = (mag2_reg[0] > mag2_reg[1]) ? mag2_reg[0] : mag2_reg[1];
        pb = (mag2_reg[2] > mag2_reg[3]) ? mag2_reg[2] : mag2_reg[3];
        peak_next = (pa > pb) ? pa : pb;
    end

    // Form the dividend per lane; unscaled items divide magnitude by one
    always_comb
    begin
        logic [mmsl_pkg::PROD_W-1:0] prod;
        for (int i = 0; i < NL; i++)
        begin
            prod = mmsl_pkg::PROD_W'(mag3_reg[i]) * mmsl_pkg::PROD_W'(lim3_reg);
            if (scale3_reg)
            begin
                lanes4_next[i].rem = prod[mmsl_pkg::PROD_W-1:mmsl_pkg::Q_W];
                lanes4_next[i].qn  = prod[mmsl_pkg::Q_W-1:0];
            end
            else
            begin
                lanes4_next[i].rem = '0;
                lanes4_next[i].qn  = mag3_reg[i][mmsl_pkg::Q_W-1:0];
            end
        end
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            v4_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= start && !busy;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            v4_reg   <= v3_reg;
            done_reg <= ctl_chain[mmsl_pkg::DIV_STAGES].valid;
        end
    end

    // Advance payload through mix, magnitude, peak and multiply stages
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NL; i++)
        begin
            sum_reg[i]  <= sum_next[i];
            mag2_reg[i] <= sum_reg[i][SW-1] ? MW'(-sum_reg[i]) : MW'(sum_reg[i]);
            neg2_reg[i] <= sum_reg[i][SW-1];
            mag3_reg[i] <= mag2_reg[i];
        end
        lim1_reg     <= speed_limit;
        lim2_reg     <= lim1_reg;
        lim3_reg     <= lim2_reg;
        neg3_reg     <= neg2_reg;
        peak3_reg    <= peak_next;
        scale3_reg   <= peak_next > MW'(lim2_reg);
        scale4_reg   <= scale3_reg;
        divisor4_reg <= scale3_reg ? peak3_reg : MW'(1);
        neg4_reg     <= neg3_reg;
        lanes4_reg   <= lanes4_next;
    end

    // Divider pipeline: one quotient bit per stage
    assign ctl_chain[0]   = {v4_reg, scale4_reg, divisor4_reg, neg4_reg};
    assign lanes_chain[0] = lanes4_reg;

    for (genvar s = 0; s < mmsl_pkg::DIV_STAGES; s++)
    begin : g_div
        mmsl_div_stage u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl_in    (ctl_chain[s]),
            .lanes_in  (lanes_chain[s]),
            .ctl_out   (ctl_chain[s+1]),
            .lanes_out (lanes_chain[s+1])
        );
    end

    // Restore the sign of each wheel
    always_comb
    begin
        logic [mmsl_pkg::OUT_W-1:0] mag;
        for (int i = 0; i < NL; i++)
        begin
            mag = mmsl_pkg::OUT_W'(lanes_chain[mmsl_pkg::DIV_STAGES][i].qn);
            wheel_next[i] = ctl_chain[mmsl_pkg::DIV_STAGES].neg[i] ? -mag : mag;
        end
    end

    // Hold the result for its one-cycle strobe
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NL; i++)
        begin
            wheel_reg[i] <= wheel_next[i];
        end
        scaled_reg <= ctl_chain[mmsl_pkg::DIV_STAGES].scale;
    end

    assign done       = done_reg;
    assign wheel_lf   = wheel_reg[mmsl_pkg::W_LF];
    assign wheel_rf   = wheel_reg[mmsl_pkg::W_RF];
    assign wheel_rb   = wheel_reg[mmsl_pkg::W_RB];
    assign wheel_lb   = wheel_reg[mmsl_pkg::W_LB];
    assign was_scaled = scaled_reg;

endmodule

// File: src/mmsl_div_stage.sv
// ----------------------------------------------------------------------------
// mmsl_div_stage: one restoring-division step for all four wheel lanes
// Brings down the next dividend bit, compares against the shared divisor,
// subtracts when it fits and shifts the quotient bit in. Registered output.
// ----------------------------------------------------------------------------
module mmsl_div_stage (
    input  logic            clk,
    input  logic            rst_n,
    input  mmsl_pkg::ctl_t  ctl_in,
    input  mmsl_pkg::lanes_t lanes_in,
    output mmsl_pkg::ctl_t  ctl_out,
    output mmsl_pkg::lanes_t lanes_out
);

    logic                              valid_reg;
    logic                              scale_reg;
    logic [mmsl_pkg::MAG_W-1:0]        divisor_reg;
    logic [mmsl_pkg::LANES-1:0]        neg_reg;
    mmsl_pkg::lanes_t lanes_reg;
    mmsl_pkg::lanes_t lanes_next;

    // Trial subtract per lane
    always_comb
    begin
        logic [mmsl_pkg::MAG_W:0] trial;
        logic [mmsl_pkg::MAG_W:0] diff;
        logic                     fits;
        for (int i = 0; i < mmsl_pkg::LANES; i++)
        begin
            trial = {lanes_in[i].rem, lanes_in[i].qn[mmsl_pkg::Q_W-1]};
            diff  = trial - {1'b0, ctl_in.divisor};
            fits  = (trial >= {1'b0, ctl_in.divisor});
            lanes_next[i].rem = fits ? diff[mmsl_pkg::MAG_W-1:0]
                                     : trial[mmsl_pkg::MAG_W-1:0];
            lanes_next[i].qn  = {lanes_in[i].qn[mmsl_pkg::Q_W-2:0], fits};
        end
    end

    // Advance valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= ctl_in.valid;
        end
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        scale_reg   <= ctl_in.scale;
        divisor_reg <= ctl_in.divisor;
        neg_reg     <= ctl_in.neg;
        lanes_reg   <= lanes_next;
    end

    assign ctl_out   = {valid_reg, scale_reg, divisor_reg, neg_reg};
    assign lanes_out = lanes_reg;

endmodule

// File: src/mmsl_checker.sv
// ----------------------------------------------------------------------------
// mmsl_checker: port-level checks for the mecanum mixer
// Watches the command and result ports for busy, latency, limit and pass-through.
// ----------------------------------------------------------------------------
module mmsl_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic signed [15:0] vx,
    input logic signed [15:0] vy,
    input logic signed [15:0] wz,
    input logic [14:0] speed_limit,
    input logic        done,
    input logic signed [15:0] wheel_lf,
    input logic signed [15:0] wheel_rf,
    input logic signed [15:0] wheel_rb,
    input logic signed [15:0] wheel_lb,
    input logic        was_scaled
);

    logic [16:0] abs_lf, abs_rf, abs_rb, abs_lb;
    logic signed [17:0] mix_lf;

    assign abs_lf = wheel_lf[15] ? 17'(-18'(wheel_lf)) : 17'(wheel_lf);
    assign abs_rf = wheel_rf[15] ? 17'(-18'(wheel_rf)) : 17'(wheel_rf);
    assign abs_rb = wheel_rb[15] ? 17'(-18'(wheel_rb)) : 17'(wheel_rb);
    assign abs_lb = wheel_lb[15] ? 17'(-18'(wheel_lb)) : 17'(wheel_lb);
    assign mix_lf = 18'(vx) + 18'(vy) + 18'(wz);

    // Never hold commands off
    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !busy)
        else $error("busy raised");

    // Each accepted item yields a result after the fixed latency
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##(mmsl_pkg::LATENCY) done)
        else $error("result missing after fixed latency");

    // No wheel exceeds the limit that came with its item
    a_within_limit: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (abs_lf <= 17'($past(speed_limit, mmsl_pkg::LATENCY)))
              && (abs_rf <= 17'($past(speed_limit, mmsl_pkg::LATENCY)))
              && (abs_rb <= 17'($past(speed_limit, mmsl_pkg::LATENCY)))
              && (abs_lb <= 17'($past(speed_limit, mmsl_pkg::LATENCY))))
        else $error("wheel speed above limit");

    // Unscaled front-left wheel equals the plain mix
    a_pass_through: assert property (@(posedge clk) disable iff (!rst_n)
        done && !was_scaled |-> 18'(wheel_lf) == $past(mix_lf, mmsl_pkg::LATENCY))
        else $error("unscaled wheel differs from mix");

endmodule

bind mecanum_mix_speed_limit mmsl_checker u_mmsl_checker (.*);
